>>> rtl/gda_pkg.sv
// Shared types, constants and calendar helpers for the date adder.
package gda_pkg;

  // Internal year width: covers the largest start year plus the largest day count
  localparam int unsigned YW         = 23;
  localparam int unsigned ERA_DAYS   = 146097;
  localparam int unsigned ERA_YEARS  = 400;
  localparam int unsigned LEAP_DAYS  = 366;
  localparam int unsigned NORM_DAYS  = 365;
  // Reciprocal of 25 on the year over 16: q = ((y >> 4) * Q_MUL) >> 16 = y / 400,
  // exact for every 16-bit year
  localparam int unsigned Q_MUL      = 2622;

  typedef struct packed {
    logic [29:0] days_to_add;
    logic [4:0]  start_day;
    logic [3:0]  start_month;
    logic [15:0] start_year;
  } gda_in_t;

  typedef struct packed {
    logic [4:0] end_day;
    logic [3:0] end_month;
  } gda_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YOE,
    ST_NORM,
    ST_ERA,
    ST_YEAR,
    ST_DAYS,
    ST_DONE
  } gda_state_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_YOE,
    CMD_NORM,
    CMD_ERA,
    CMD_YEAR,
    CMD_DAY,
    CMD_PUB
  } gda_cmd_t;

  typedef struct packed {
    logic era_ok;   // remaining count covers a full 400-year era
    logic year_ok;  // remaining count covers the coming year
    logic feb29;    // current date is Feb 29
    logic n_zero;   // no days left
  } gda_stat_t;

  // Leap test from the year of era (year mod 400)
  function automatic logic is_leap(input logic [8:0] yoe);
    logic res;
    res = (yoe[1:0] == 2'd0) && (yoe != 9'd100) && (yoe != 9'd200) && (yoe != 9'd300);
    return res;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    if (m == 4'd2) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

endpackage

>>> rtl/gda_datapath.sv
// Datapath: date registers, remaining-day counter and output register.
module gda_datapath #(
  parameter int unsigned YEAR_BITS = 22
) (
  input  logic                    clk,
  input  gda_pkg::gda_cmd_t       cmd,
  input  gda_pkg::gda_in_t        in_data,
  output gda_pkg::gda_stat_t      stat,
  output gda_pkg::gda_out_t       out_data,
  output logic [YEAR_BITS-1:0]    out_end_year
);
  import gda_pkg::*;

  logic [29:0]    n_r;
  logic [4:0]     d_r;
  logic [3:0]     m_r;
  logic [YW-1:0]  y_r;
  logic [8:0]     yoe_r;
  logic [7:0]     q_r;
  gda_out_t       out_r;
  logic [YEAR_BITS-1:0] out_year_r;

  logic [3:0]  m_clamp;
  logic [23:0] q_prod;
  logic [15:0] q400;
  logic [8:0]  yoe_new;
  logic [8:0]  yoe_inc;
  logic        leap_cur;
  logic        leap_next;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic        ovf;

  // Month clamp and year-mod-400 by reciprocal
  always_comb begin
    if (in_data.start_month == 4'd0) begin
      m_clamp = 4'd1;
    end else if (in_data.start_month > 4'd12) begin
      m_clamp = 4'd12;
    end else begin
      m_clamp = in_data.start_month;
    end
  end

  assign q_prod  = 24'(in_data.start_year[15:4]) * 24'(Q_MUL);
  assign q400    = 16'(q_r) * 16'(ERA_YEARS);
  assign yoe_new = 9'(y_r[15:0] - q400);

  // Calendar lengths from the current date
  assign yoe_inc   = (yoe_r == 9'd399) ? 9'd0 : yoe_r + 9'd1;
  assign leap_cur  = is_leap(yoe_r);
  assign leap_next = is_leap(yoe_inc);
  // Next Feb 29 ahead: this year's in Jan/Feb, next year's otherwise
  assign ylen = (m_r <= 4'd2) ? (leap_cur  ? 9'(LEAP_DAYS) : 9'(NORM_DAYS))
                              : (leap_next ? 9'(LEAP_DAYS) : 9'(NORM_DAYS));
  assign mlen = month_len(m_r, leap_cur);

  // Status to the controller
  assign stat.era_ok  = (n_r >= 30'(ERA_DAYS));
  assign stat.year_ok = (n_r >= 30'(ylen));
  assign stat.feb29   = (m_r == 4'd2) && (d_r == 5'd29);
  assign stat.n_zero  = (n_r == 30'd0);

  assign ovf = ((y_r >> YEAR_BITS) != '0);

  // Register updates by command
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        n_r <= in_data.days_to_add;
        d_r <= in_data.start_day;
        m_r <= m_clamp;
        y_r <= YW'(in_data.start_year);
        q_r <= q_prod[23:16];
      end
      CMD_YOE: begin
        yoe_r <= yoe_new;
      end
      CMD_NORM: begin
        if (d_r == 5'd0) begin
          d_r <= 5'd1;
        end else if (d_r > mlen) begin
          d_r <= mlen;
        end
      end
      CMD_ERA: begin
        n_r <= n_r - 30'(ERA_DAYS);
        y_r <= y_r + YW'(ERA_YEARS);
      end
      CMD_YEAR: begin
        n_r   <= n_r - 30'(ylen);
        y_r   <= y_r + YW'(1);
        yoe_r <= yoe_inc;
      end
      CMD_DAY: begin
        n_r <= n_r - 30'd1;
        if (d_r < mlen) begin
          d_r <= d_r + 5'd1;
        end else begin
          d_r <= 5'd1;
          if (m_r == 4'd12) begin
            m_r   <= 4'd1;
            y_r   <= y_r + YW'(1);
            yoe_r <= yoe_inc;
          end else begin
            m_r <= m_r + 4'd1;
          end
        end
      end
      CMD_PUB: begin
        // Saturate past the top year
        if (ovf) begin
          out_r.end_day   <= 5'd31;
          out_r.end_month <= 4'd12;
          out_year_r      <= '1;
        end else begin
          out_r.end_day   <= d_r;
          out_r.end_month <= m_r;
          out_year_r      <= YEAR_BITS'(y_r);
        end
      end
      default: ;
    endcase
  end

  assign out_data     = out_r;
  assign out_end_year = out_year_r;

endmodule

>>> rtl/gda_ctrl.sv
// Controller: sequences era, year and day steps and owns both handshakes.
module gda_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  gda_pkg::gda_stat_t  stat,
  output gda_pkg::gda_cmd_t   cmd
);
  import gda_pkg::*;

  gda_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       can_pub;

  assign can_pub = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_YOE;
      ST_YOE:  state_nxt = ST_NORM;
      ST_NORM: state_nxt = ST_ERA;
      ST_ERA:  if (!stat.era_ok) state_nxt = ST_YEAR;
      ST_YEAR: begin
        if (!(stat.feb29 && !stat.n_zero) && !stat.year_ok) state_nxt = ST_DAYS;
      end
      ST_DAYS: if (stat.n_zero) state_nxt = ST_DONE;
      ST_DONE: if (can_pub) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands and handshake outputs
  always_comb begin
    cmd      = CMD_NONE;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd = CMD_LOAD;
      end
      ST_YOE:  cmd = CMD_YOE;
      ST_NORM: cmd = CMD_NORM;
      ST_ERA:  if (stat.era_ok) cmd = CMD_ERA;
      ST_YEAR: begin
        // Step off Feb 29 first so whole-year skips never land on a missing day
        if (stat.feb29 && !stat.n_zero) begin
          cmd = CMD_DAY;
        end else if (stat.year_ok) begin
          cmd = CMD_YEAR;
        end
      end
      ST_DAYS: if (!stat.n_zero) cmd = CMD_DAY;
      ST_DONE: if (can_pub) cmd = CMD_PUB;
      default: ;
    endcase
  end

  assign out_valid_nxt = (cmd == CMD_PUB) || (out_valid_r && !out_ready);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/gregorian_date_add_days.sv
// Top level of the Gregorian date adder: controller plus datapath.
//
// Usage: present a start date and a day count as one beat on in_valid/in_ready;
// the block returns the date that many days later as one beat on out_valid/out_ready.
// A start month of 0 reads as January and 13..15 as December; a start day of 0 reads
// as 1 and a day past the month end as the month's last day. A resulting year beyond
// 2^YEAR_BITS-1 gives Dec 31 of that top year.
// Order of work: the controller takes whole 400-year eras off the count (up to 7349),
// then the remaining whole years (up to 399), then the remaining single days (up to
// 365); a start on Feb 29 with a nonzero count is first stepped one day, off Feb 29,
// before the year steps. The single subtract/compare path in the datapath takes one
// step per cycle. The next beat can be taken in the same cycle that out_valid rises.
// One item is in work at a time; in_ready is high only while the controller is idle,
// which includes the time a finished result waits in the output register.
// A stalled receiver holds out_valid and the payload; a finished item then waits
// until the output register frees. Synchronous active-low reset clears the
// controller and drops out_valid; the datapath registers are not reset.
module gregorian_date_add_days #(
  parameter int unsigned YEAR_BITS = 22
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gda_pkg::gda_in_t      in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gda_pkg::gda_out_t     out_data,
  output logic [YEAR_BITS-1:0]  out_end_year
);
  import gda_pkg::*;

  gda_cmd_t  cmd;
  gda_stat_t stat;

  gda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gda_datapath #(
    .YEAR_BITS (YEAR_BITS)
  ) u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .in_data      (in_data),
    .stat         (stat),
    .out_data     (out_data),
    .out_end_year (out_end_year)
  );

endmodule

>>> rtl/gda_checker.sv
// Port-level checker for the date adder and its bind to the top level.
module gda_checker #(
  parameter int unsigned YEAR_BITS = 22
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input gda_pkg::gda_out_t     out_data,
  input logic [YEAR_BITS-1:0]  out_end_year
);
  import gda_pkg::*;

  // Reset drops the output beat
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // Stalled beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data) && $stable(out_end_year))
    else $error("output payload changed while stalled");

  // One item at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in work");

  // Every result has a month in 1..12 and a day in 1..31
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.end_month >= 4'd1) && (out_data.end_month <= 4'd12) &&
                  (out_data.end_day >= 5'd1) && (out_data.end_day <= 5'd31))
    else $error("result date out of range");

endmodule

bind gregorian_date_add_days gda_checker #(.YEAR_BITS(YEAR_BITS)) u_gda_checker (.*);

>>> sim/tb_top.sv
// Self-checking testbench for the Gregorian date adder: directed table, random dates, backpressure.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gda_pkg::*;

  localparam int unsigned       YEAR_BITS = 22;
  localparam longint unsigned   YEAR_MAX  = (64'd1 << YEAR_BITS) - 1;
  localparam longint unsigned   ERA_LEN   = 146097;
  // Year bias so that Jan/Feb of year 0 never underflows the day index
  localparam longint unsigned   YEAR_BIAS = 400;
  localparam int                HOLD_OFF  = 600;
  localparam int                N_RANDOM  = 80;

  typedef struct packed {
    logic [4:0]           day;
    logic [3:0]           month;
    logic [YEAR_BITS-1:0] year;
  } date_t;

  typedef struct {
    gda_in_t stim;
    bit      typed;
    date_t   want;
  } plan_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  gda_in_t              in_data;
  logic                 out_valid;
  logic                 out_ready;
  gda_out_t             out_data;
  logic [YEAR_BITS-1:0] out_end_year;

  date_t     due_dates[$];
  plan_row_t plan_rows[$];
  int        errors        = 0;
  int        sent          = 0;
  int        taken         = 0;
  int        long_counts   = 0;
  int        clamped       = 0;
  int        input_blocked = 0;

  gregorian_date_add_days #(
    .YEAR_BITS(YEAR_BITS)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .out_end_year(out_end_year)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // ---------------------------------------------------------------- calendar predictor
  function automatic bit leap_year(input longint unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic longint unsigned month_days(input longint unsigned m,
                                                 input longint unsigned y);
    if (m == 2) return leap_year(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  // Days since a fixed epoch; the year is counted from March so Feb 29 ends it
  function automatic longint unsigned day_index(input longint unsigned y,
                                                input longint unsigned m,
                                                input longint unsigned d);
    longint unsigned yy, era, yoe, mp, doy, doe;
    yy  = (m <= 2) ? y - 1 : y;
    era = yy / 400;
    yoe = yy - era * 400;
    mp  = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * ERA_LEN + doe;
  endfunction

  // Expected end date for one input beat
  function automatic date_t date_after(input gda_in_t item);
    longint unsigned y, m, d, z, era, doe, yoe, doy, mp, ry, rm, rd;
    date_t res;
    y = 64'(item.start_year);
    m = 64'(item.start_month);
    d = 64'(item.start_day);
    // clamp month, then day to the month's length
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    if (d < 1) d = 1;
    if (d > month_days(m, y)) d = month_days(m, y);
    z   = day_index(y + YEAR_BIAS, m, d) + 64'(item.days_to_add);
    era = z / ERA_LEN;
    doe = z - era * ERA_LEN;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    ry  = yoe + era * 400;
    rd  = doy - (153 * mp + 2) / 5 + 1;
    rm  = (mp < 10) ? mp + 3 : mp - 9;
    if (rm <= 2) ry = ry + 1;
    ry = ry - YEAR_BIAS;
    // saturate past the top year
    if (ry > YEAR_MAX) begin
      ry = YEAR_MAX;
      rm = 12;
      rd = 31;
    end
    res.day   = rd[4:0];
    res.month = rm[3:0];
    res.year  = ry[YEAR_BITS-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers
  task automatic put_row(input longint unsigned n, input int d, input int m, input int y,
                         input bit typed, input int ed = 0, input int em = 0,
                         input int ey = 0);
    plan_row_t r;
    r.stim.days_to_add = 30'(n);
    r.stim.start_day   = 5'(d);
    r.stim.start_month = 4'(m);
    r.stim.start_year  = 16'(y);
    r.typed            = typed;
    r.want.day         = 5'(ed);
    r.want.month       = 4'(em);
    r.want.year        = YEAR_BITS'(ey);
    plan_rows.push_back(r);
  endtask

  // Mostly well-formed dates with short counts; some full-range counts and junk fields
  function automatic gda_in_t random_date_item();
    gda_in_t item;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick <= 4) item.days_to_add = 30'($urandom_range(0, 800));
    else if (pick <= 6) item.days_to_add = 30'($urandom_range(0, 150000));
    else if (pick == 7) item.days_to_add = 30'(ERA_LEN * $urandom_range(1, 3) +
                                              $urandom_range(0, 400));
    else item.days_to_add = 30'($urandom());
    // years near century and era boundaries now and then
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 5))
        0: item.start_year = 16'd0;
        1: item.start_year = 16'd100;
        2: item.start_year = 16'd400;
        3: item.start_year = 16'd1900;
        4: item.start_year = 16'd2000;
        default: item.start_year = 16'd2100;
      endcase
      item.start_year = 16'(item.start_year + $urandom_range(0, 4));
    end else begin
      item.start_year = 16'($urandom());
    end
    if ($urandom_range(0, 6) == 0) begin
      item.start_day   = 5'($urandom());
      item.start_month = 4'($urandom());
    end else begin
      item.start_month = 4'($urandom_range(1, 12));
      item.start_day   = 5'($urandom_range(1, 32'(month_days(item.start_month,
                                                             item.start_year))));
    end
    return item;
  endfunction

  // One input beat; gaps are off for every third block of 16 items
  task automatic send_date(input gda_in_t item, input date_t want);
    int gap;
    gap = ((sent / 16) % 3 != 0) ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    due_dates.push_back(want);
    sent++;
    if (item.days_to_add >= ERA_LEN) long_counts++;
    if (item.start_month == 0 || item.start_month > 12 || item.start_day == 0 ||
        item.start_day > month_days(item.start_month, item.start_year)) clamped++;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------- main sequence
  initial begin
    gda_in_t item;
    date_t   want;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero counts: clamping of month and day
    put_row(0, 1, 1, 0, 1, 1, 1, 0);
    put_row(0, 0, 0, 0, 1, 1, 1, 0);
    put_row(0, 31, 15, 65535, 1, 31, 12, 65535);
    put_row(0, 29, 2, 1900, 1, 28, 2, 1900);
    put_row(0, 29, 2, 0, 1, 29, 2, 0);
    put_row(0, 31, 4, 2023, 1, 30, 4, 2023);
    put_row(0, 30, 2, 2024, 1, 29, 2, 2024);
    put_row(0, 31, 0, 5, 1, 31, 1, 5);
    put_row(0, 0, 13, 100, 1, 1, 12, 100);
    // single-day rollovers across year, leap day and century
    put_row(1, 31, 12, 1999, 1, 1, 1, 2000);
    put_row(1, 28, 2, 2000, 1, 29, 2, 2000);
    put_row(1, 28, 2, 2100, 1, 1, 3, 2100);
    put_row(1, 29, 2, 400, 1, 1, 3, 400);
    // Feb 29 plus a year, whole years and a whole era
    put_row(366, 29, 2, 2000, 1, 1, 3, 2001);
    put_row(365, 1, 1, 2001, 1, 1, 1, 2002);
    put_row(146097, 1, 1, 2000, 1, 1, 1, 2400);
    put_row(146096, 1, 3, 2000, 0);
    // largest counts
    put_row(30'h3FFF_FFFF, 1, 1, 0, 0);
    put_row(30'h3FFF_FFFF, 31, 12, 65535, 0);
    put_row(30'h2AAA_AAAA, 21, 10, 43690, 0);

    foreach (plan_rows[i]) begin
      want = plan_rows[i].typed ? plan_rows[i].want : date_after(plan_rows[i].stim);
      send_date(plan_rows[i].stim, want);
    end

    repeat (N_RANDOM) begin
      item = random_date_item();
      send_date(item, date_after(item));
    end
    in_valid <= 1'b0;

    while (due_dates.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("Covered %0d start dates (%0d from the table), %0d counts past one era, %0d clamped.",
             sent, plan_rows.size(), long_counts, clamped);
    $display("Checked %0d end dates; input stalled %0d cycles under output backpressure.",
             taken, input_blocked);
    if (errors == 0) begin
      $display("gregorian_date_add_days verification clean");
    end else begin
      $display("gregorian_date_add_days verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------- result receiver
  // Random stalls, calm blocks of 12 beats, and one long hold-off to back the block up
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (taken == 10) stall = HOLD_OFF;
      else if ((taken / 12) % 3 != 0) stall = $urandom_range(0, 14);
      else stall = 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------- result checker
  always @(posedge clk) begin
    date_t want;
    if (rst_n && out_valid && out_ready) begin
      taken++;
      if (due_dates.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected beat: got %0d-%0d-%0d", out_end_year, out_data.end_month,
                   out_data.end_day);
        end
      end else begin
        want = due_dates.pop_front();
        if (out_data.end_day !== want.day || out_data.end_month !== want.month ||
            out_end_year !== want.year) begin
          errors++;
          if (errors <= 10) begin
            $display("date mismatch on beat %0d: expected %0d-%0d-%0d, got %0d-%0d-%0d",
                     taken, want.year, want.month, want.day,
                     out_end_year, out_data.end_month, out_data.end_day);
          end
        end
      end
    end
  end

  // Input beats refused while valid is up
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_ready) input_blocked++;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("gregorian_date_add_days verification failed");
    $finish;
  end

endmodule
